FILE: hw/rtl/mrf_pkg.sv
// Shared types and constants for the message ring FIFO.
// Holds operation and status codes, field widths and the result record.
// Used by mrf_ctrl and message_ring_fifo_top; depends on nothing.
package mrf_pkg;

	localparam int LEN_W   = 13;
	localparam int BYTE_W  = 8;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 5;
	localparam int FREE_W  = 13;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
	localparam logic [OP_W-1:0] OP_POP   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO_LEN = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_PUSH  = 3'd4;
	localparam logic [STAT_W-1:0] ST_BUSY     = 3'd5;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               byte_sel;
		logic               end_of_message;
		logic [LEN_W-1:0]   head_length;
		logic [COUNT_W-1:0] message_count;
		logic [FREE_W-1:0]  free_bytes;
	} result_t;

endpackage

FILE: hw/rtl/mrf_ram.sv
// Simple dual-port memory with a registered, write-first read port.
// Used for the message byte store and the message length queue.
// Depends on nothing.
module mrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/mrf_ctrl.sv
// Control state of the message ring FIFO: pointers, counts and open push.
// Decides each operation combinationally and drives both memories.
// Depends on mrf_pkg.
module mrf_ctrl #(
	parameter int BUFFER_BYTES = 4096,
	parameter int MAX_MESSAGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [mrf_pkg::OP_W-1:0]          op_s1,
	input  logic [mrf_pkg::LEN_W-1:0]         len_s1,
	input  logic [mrf_pkg::BYTE_W-1:0]        data_s1,
	input  logic [mrf_pkg::LEN_W-1:0]         lq_rdata,
	output mrf_pkg::result_t                  res,
	output logic                              bs_we,
	output logic [$clog2(BUFFER_BYTES)-1:0]   bs_waddr,
	output logic [mrf_pkg::BYTE_W-1:0]        bs_wdata,
	output logic [$clog2(BUFFER_BYTES)-1:0]   bs_raddr,
	output logic                              lq_we,
	output logic [$clog2(MAX_MESSAGES)-1:0]   lq_waddr,
	output logic [mrf_pkg::LEN_W-1:0]         lq_wdata,
	output logic [$clog2(MAX_MESSAGES)-1:0]   lq_raddr
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int UW = $clog2(BUFFER_BYTES + 1);
	localparam int QW = $clog2(MAX_MESSAGES);
	localparam int CW = $clog2(MAX_MESSAGES + 1);
	localparam int SW = CW + 1;
	localparam int LW = mrf_pkg::LEN_W;

	logic [AW-1:0] wr_idx_q, wr_idx_n, rd_idx_q, rd_idx_n;
	logic [UW-1:0] used_q, used_n, free_now;
	logic [CW-1:0] count_q, count_n;
	logic [QW-1:0] qhead_q, qhead_n, qhead_cur;
	logic [LW-1:0] push_rem_q, push_rem_n, push_len_q, push_len_n;
	logic [LW-1:0] pop_off_q, pop_off_n, pop_off_inc, head_len_q, head_len_n;
	logic [SW-1:0] slot_sum;
	logic [31:0]   count_wide, free_wide;

	assign free_now    = UW'(BUFFER_BYTES) - used_q;
	assign pop_off_inc = pop_off_q + LW'(1);
	assign slot_sum    = SW'(qhead_q) + SW'(count_q);

	always_comb begin
		wr_idx_n         = wr_idx_q;
		rd_idx_n         = rd_idx_q;
		used_n           = used_q;
		count_n          = count_q;
		qhead_n          = qhead_q;
		push_rem_n       = push_rem_q;
		push_len_n       = push_len_q;
		pop_off_n        = pop_off_q;
		head_len_n       = head_len_q;
		res.status       = mrf_pkg::ST_OK;
		res.byte_sel     = 1'b0;
		res.end_of_message = 1'b0;
		bs_we            = 1'b0;
		lq_we            = 1'b0;
		unique case (op_s1)
			mrf_pkg::OP_START: begin
				priority if (push_rem_q != '0) begin
					res.status = mrf_pkg::ST_BUSY;
				end else if (len_s1 == '0) begin
					res.status = mrf_pkg::ST_ZERO_LEN;
				end else if ((32'(free_now) < 32'(len_s1)) ||
						(count_q == CW'(MAX_MESSAGES))) begin
					res.status = mrf_pkg::ST_FULL;
				end else begin
					push_rem_n = len_s1;
					push_len_n = len_s1;
				end
			end
			mrf_pkg::OP_PUSH: begin
				if (push_rem_q == '0) begin
					res.status = mrf_pkg::ST_NO_PUSH;
				end else begin
					bs_we      = fire;
					wr_idx_n   = (wr_idx_q == AW'(BUFFER_BYTES - 1)) ? '0 : wr_idx_q + AW'(1);
					used_n     = used_q + UW'(1);
					push_rem_n = push_rem_q - LW'(1);
					if (push_rem_q == LW'(1)) begin
						lq_we      = fire;
						count_n    = count_q + CW'(1);
						push_len_n = '0;
						if (count_q == '0) begin
							head_len_n = push_len_q;
						end
					end
				end
			end
			mrf_pkg::OP_POP: begin
				if (count_q == '0) begin
					res.status = mrf_pkg::ST_EMPTY;
				end else begin
					res.byte_sel = 1'b1;
					rd_idx_n     = (rd_idx_q == AW'(BUFFER_BYTES - 1)) ? '0 : rd_idx_q + AW'(1);
					used_n       = used_q - UW'(1);
					pop_off_n    = pop_off_inc;
					if (pop_off_inc >= head_len_q) begin
						res.end_of_message = 1'b1;
						pop_off_n  = '0;
						qhead_n    = (qhead_q == QW'(MAX_MESSAGES - 1)) ? '0 : qhead_q + QW'(1);
						count_n    = count_q - CW'(1);
						head_len_n = lq_rdata;
					end
				end
			end
			default: begin
				res.status = mrf_pkg::ST_OK;
			end
		endcase
		count_wide        = 32'(count_n);
		free_wide         = 32'(UW'(BUFFER_BYTES) - used_n);
		res.head_length   = (count_n != '0) ? head_len_n : '0;
		res.message_count = count_wide[mrf_pkg::COUNT_W-1:0];
		res.free_bytes    = free_wide[mrf_pkg::FREE_W-1:0];
	end

	assign bs_waddr = wr_idx_q;
	assign bs_wdata = data_s1;
	assign bs_raddr = rd_idx_q;
	assign lq_waddr = QW'((slot_sum >= SW'(MAX_MESSAGES)) ? slot_sum - SW'(MAX_MESSAGES) : slot_sum);
	assign lq_wdata = push_len_q;
	assign qhead_cur = fire ? qhead_n : qhead_q;
	assign lq_raddr = (qhead_cur == QW'(MAX_MESSAGES - 1)) ? '0 : qhead_cur + QW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			used_q     <= '0;
			count_q    <= '0;
			qhead_q    <= '0;
			push_rem_q <= '0;
			push_len_q <= '0;
			pop_off_q  <= '0;
			head_len_q <= '0;
		end else if (fire) begin
			wr_idx_q   <= wr_idx_n;
			rd_idx_q   <= rd_idx_n;
			used_q     <= used_n;
			count_q    <= count_n;
			qhead_q    <= qhead_n;
			push_rem_q <= push_rem_n;
			push_len_q <= push_len_n;
			pop_off_q  <= pop_off_n;
			head_len_q <= head_len_n;
		end
	end

endmodule

FILE: hw/rtl/message_ring_fifo_top.sv
// Top level of the message ring FIFO: stream ports, pipeline and memories.
// Instantiates mrf_ctrl and two mrf_ram blocks; depends on mrf_pkg.
//
// Usage: each input transaction carries one operation in s_tuser (start a
// message of msg_len bytes, push one byte, or pop one byte). Every input
// transaction yields exactly one output transaction with a status in
// m_tuser, the popped byte and queue information in m_tdata, and m_tlast
// set on the final byte of a message.
// Throughput is one transaction per cycle while m_tready is high. The
// input register takes a transaction at its accepting edge and the output
// register takes its result when the output can advance; the byte memory
// is read at that edge, and the length memory is read at every edge.
// When the receiver holds m_tready low, the output register holds its
// result, and one further input transaction is still taken if the input
// register is empty; after that s_tready drops until the output drains.
// Reset clears all pointers and counts; the memories are not cleared and
// need no pass after reset, so the block is ready in the first cycle.
module message_ring_fifo_top #(
	parameter int BUFFER_BYTES = 4096,
	parameter int MAX_MESSAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // msg_len[12:0], data_byte[20:13], zero fill
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // byte_out[7:0], head_length[20:8],
	                              // message_count[25:21], free_bytes[38:26]
	output logic [2:0]  m_tuser,  // status[2:0]
	output logic        m_tlast   // end_of_message
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int QW = $clog2(MAX_MESSAGES);

	logic                            valid_s1, valid_s2, advance, fire;
	logic [mrf_pkg::OP_W-1:0]        op_s1;
	logic [mrf_pkg::LEN_W-1:0]       len_s1;
	logic [mrf_pkg::BYTE_W-1:0]      data_s1;
	mrf_pkg::result_t                res, res_s2;
	logic                            bs_we, lq_we;
	logic [AW-1:0]                   bs_waddr, bs_raddr;
	logic [mrf_pkg::BYTE_W-1:0]      bs_wdata, bs_rdata, byte_out;
	logic [QW-1:0]                   lq_waddr, lq_raddr;
	logic [mrf_pkg::LEN_W-1:0]       lq_wdata, lq_rdata;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			len_s1  <= s_tdata[12:0];
			data_s1 <= s_tdata[20:13];
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	mrf_ctrl #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.MAX_MESSAGES(MAX_MESSAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.op_s1    (op_s1),
		.len_s1   (len_s1),
		.data_s1  (data_s1),
		.lq_rdata (lq_rdata),
		.res      (res),
		.bs_we    (bs_we),
		.bs_waddr (bs_waddr),
		.bs_wdata (bs_wdata),
		.bs_raddr (bs_raddr),
		.lq_we    (lq_we),
		.lq_waddr (lq_waddr),
		.lq_wdata (lq_wdata),
		.lq_raddr (lq_raddr)
	);

	mrf_ram #(
		.WIDTH(mrf_pkg::BYTE_W),
		.DEPTH(BUFFER_BYTES)
	) u_byte_store (
		.clk   (clk),
		.we    (bs_we),
		.waddr (bs_waddr),
		.wdata (bs_wdata),
		.re    (fire),
		.raddr (bs_raddr),
		.rdata (bs_rdata)
	);

	mrf_ram #(
		.WIDTH(mrf_pkg::LEN_W),
		.DEPTH(MAX_MESSAGES)
	) u_length_queue (
		.clk   (clk),
		.we    (lq_we),
		.waddr (lq_waddr),
		.wdata (lq_wdata),
		.re    (1'b1),
		.raddr (lq_raddr),
		.rdata (lq_rdata)
	);

	assign byte_out = res_s2.byte_sel ? bs_rdata : '0;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.free_bytes, res_s2.message_count,
		res_s2.head_length, byte_out};
	assign m_tuser  = res_s2.status;
	assign m_tlast  = res_s2.end_of_message;

	a_last_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == mrf_pkg::ST_OK)
		else $error("End of message flagged on a failed transaction.");

	a_empty_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == mrf_pkg::ST_EMPTY) |-> m_tdata[25:21] == '0)
		else $error("Empty status reported while messages are held.");

	a_byte_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s2.byte_sel |-> m_tdata[7:0] == '0 && !m_tlast)
		else $error("Byte or end of message shown on a non-pop result.");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("Input stalled while the output register is empty.");

endmodule
